FILE: hw/rtl/fct_pkg.sv
`default_nettype none

package fct_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned FLOW_IDX_W  = 4;

  localparam logic [15:0] ETH_IPV4   = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_IPV4  = 2'd1;
  localparam logic [1:0] ST_BAD_PROTO = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // normalized lookup key plus the sender and status of the current packet
  typedef struct packed {
    logic [7:0]  proto;
    logic [63:0] addr_pair;
    logic [31:0] port_pair;
    logic [31:0] snd_addr;
    logic [15:0] snd_port;
    logic [1:0]  status;
  } key_t;

  typedef struct packed {
    logic [7:0]  proto;
    logic [63:0] addr_pair;
    logic [31:0] port_pair;
    logic [31:0] first_addr;
    logic [15:0] first_port;
    logic        established;
  } entry_t;

endpackage

`default_nettype wire

FILE: hw/rtl/flow_conn_tracker.sv
// Connection tracker over a flow table held in one synchronous RAM.
// done_o is registered. Non-IPv4 or unsupported protocol finishes without a table scan;
// otherwise valid entries are read in order (one RAM read a cycle) until a hit or, on a miss, all are read.
// Throughput: busy covers the scan; the next packet is accepted while done_o is high.
// done_o pulses one cycle; the receiver cannot stall.
// Reset clears the entry count; table contents are not cleared.
`default_nettype none

module flow_conn_tracker #(
  parameter int unsigned TableDepth = fct_pkg::TABLE_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] ether_type_i,
  input  wire logic [7:0]  ip_protocol_i,
  input  wire logic [31:0] ip_saddr_i,
  input  wire logic [31:0] ip_daddr_i,
  input  wire logic [15:0] l4_sport_i,
  input  wire logic [15:0] l4_dport_i,
  output logic             done_o,
  output logic             flow_state_o,
  output logic             direction_o,
  output logic [1:0]       status_o,
  output logic [3:0]       flow_index_o
);

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam int unsigned OutW = fct_pkg::FLOW_IDX_W;

  localparam logic SIdle = 1'b0;
  localparam logic SScan = 1'b1;

  logic            state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] ptr_q, ptr_d;
  logic            cmp_valid_q, cmp_valid_d;
  logic [IdxW-1:0] cmp_idx_q, cmp_idx_d;
  fct_pkg::key_t   key_in;
  fct_pkg::key_t   key_q;

  logic            done_q, done_d;
  logic            fstate_q, fstate_d;
  logic            dir_q, dir_d;
  logic [1:0]      status_q, status_d;
  logic [IdxW-1:0] idx_q, idx_d;

  logic            rd_en;
  fct_pkg::entry_t rd_data;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  fct_pkg::entry_t wr_data;

  logic            accept;
  logic            match;
  logic            fwd;
  logic            last;
  logic            full;
  logic [IdxW+OutW-1:0] idx_ext;

  fct_key u_key (
    .ether_type_i  (ether_type_i),
    .ip_protocol_i (ip_protocol_i),
    .ip_saddr_i    (ip_saddr_i),
    .ip_daddr_i    (ip_daddr_i),
    .l4_sport_i    (l4_sport_i),
    .l4_dport_i    (l4_dport_i),
    .key_o         (key_in)
  );

  fct_table #(
    .TableDepth (TableDepth),
    .IdxW       (IdxW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (ptr_q[IdxW-1:0]),
    .rd_data_o (rd_data)
  );

  assign busy   = (state_q == SScan);
  assign accept = start && !busy;

  // rd_data belongs to entry cmp_idx_q when cmp_valid_q is set
  assign match = cmp_valid_q && (rd_data.proto == key_q.proto) &&
                 (rd_data.addr_pair == key_q.addr_pair) &&
                 (rd_data.port_pair == key_q.port_pair);
  assign fwd   = (rd_data.first_addr == key_q.snd_addr) &&
                 (rd_data.first_port == key_q.snd_port);
  assign last  = (ptr_q == count_q);
  assign full  = (count_q == CntW'(TableDepth));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    cmp_valid_d = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    done_d      = 1'b0;
    fstate_d    = 1'b0;
    dir_d       = 1'b0;
    status_d    = status_q;
    idx_d       = '0;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = cmp_idx_q;
    wr_data     = rd_data;

    case (state_q)
      SIdle: begin
        if (accept) begin
          ptr_d = '0;
          if (key_in.status != fct_pkg::ST_OK) begin
            done_d   = 1'b1;
            status_d = key_in.status;
          end else begin
            state_d = SScan;
          end
        end
      end
      SScan: begin
        rd_en       = !last;
        cmp_valid_d = !last;
        cmp_idx_d   = ptr_q[IdxW-1:0];
        if (!last) begin
          ptr_d = ptr_q + CntW'(1);
        end
        if (match) begin
          state_d  = SIdle;
          done_d   = 1'b1;
          status_d = fct_pkg::ST_OK;
          idx_d    = cmp_idx_q;
          if (fwd) begin
            fstate_d = rd_data.established;
          end else begin
            fstate_d                = 1'b1;
            dir_d                   = 1'b1;
            wr_en                   = 1'b1;
            wr_data.established     = 1'b1;
          end
        end else if (last) begin
          state_d = SIdle;
          done_d  = 1'b1;
          if (full) begin
            status_d = fct_pkg::ST_FULL;
          end else begin
            status_d            = fct_pkg::ST_OK;
            idx_d               = count_q[IdxW-1:0];
            wr_en               = 1'b1;
            wr_addr             = count_q[IdxW-1:0];
            wr_data.proto       = key_q.proto;
            wr_data.addr_pair   = key_q.addr_pair;
            wr_data.port_pair   = key_q.port_pair;
            wr_data.first_addr  = key_q.snd_addr;
            wr_data.first_port  = key_q.snd_port;
            wr_data.established = 1'b0;
            count_d             = count_q + CntW'(1);
          end
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      cmp_valid_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cmp_valid_q <= cmp_valid_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    cmp_idx_q <= cmp_idx_d;
    fstate_q  <= fstate_d;
    dir_q     <= dir_d;
    status_q  <= status_d;
    idx_q     <= idx_d;
    if (accept) begin
      key_q <= key_in;
    end
  end

  assign idx_ext      = {{OutW{1'b0}}, idx_q};
  assign done_o       = done_q;
  assign flow_state_o = fstate_q;
  assign direction_o  = dir_q;
  assign status_o     = status_q;
  assign flow_index_o = idx_ext[OutW-1:0];

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TableDepth))
    else $error("entry count above table size");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == $past(count_q) + CntW'(1)))
    else $error("entry count moved by other than one");

  a_wr_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == SScan) && (match || last))
    else $error("table write outside lookup decision");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (status_q == fct_pkg::ST_FULL)) |-> (count_q == CntW'(TableDepth)))
    else $error("table full reported with free entries");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (status_q != fct_pkg::ST_OK)) |-> (idx_q == '0) && !fstate_q && !dir_q)
    else $error("error result with nonzero fields");

endmodule

`default_nettype wire

FILE: hw/rtl/fct_key.sv
`default_nettype none

module fct_key (
  input  wire logic [15:0] ether_type_i,
  input  wire logic [7:0]  ip_protocol_i,
  input  wire logic [31:0] ip_saddr_i,
  input  wire logic [31:0] ip_daddr_i,
  input  wire logic [15:0] l4_sport_i,
  input  wire logic [15:0] l4_dport_i,
  output fct_pkg::key_t    key_o
);

  logic        is_icmp;
  logic        proto_ok;
  logic [15:0] sp;
  logic [15:0] dp;
  logic        a_lt;
  logic        p_lt;

  assign is_icmp  = (ip_protocol_i == fct_pkg::PROTO_ICMP);
  assign proto_ok = is_icmp || (ip_protocol_i == fct_pkg::PROTO_TCP) ||
                    (ip_protocol_i == fct_pkg::PROTO_UDP);
  assign sp   = is_icmp ? 16'd0 : l4_sport_i;
  assign dp   = is_icmp ? 16'd0 : l4_dport_i;
  assign a_lt = ip_saddr_i < ip_daddr_i;
  assign p_lt = sp < dp;

  always_comb begin
    key_o.proto     = ip_protocol_i;
    key_o.addr_pair = a_lt ? {ip_daddr_i, ip_saddr_i} : {ip_saddr_i, ip_daddr_i};
    key_o.port_pair = p_lt ? {dp, sp} : {sp, dp};
    key_o.snd_addr  = ip_saddr_i;
    key_o.snd_port  = sp;
    if (ether_type_i != fct_pkg::ETH_IPV4) begin
      key_o.status = fct_pkg::ST_NOT_IPV4;
    end else if (!proto_ok) begin
      key_o.status = fct_pkg::ST_BAD_PROTO;
    end else begin
      key_o.status = fct_pkg::ST_OK;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fct_table.sv
`default_nettype none

module fct_table #(
  parameter int unsigned TableDepth = fct_pkg::TABLE_DEPTH,
  parameter int unsigned IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            wr_en_i,
  input  wire logic [IdxW-1:0] wr_addr_i,
  input  wire fct_pkg::entry_t wr_data_i,
  input  wire logic            rd_en_i,
  input  wire logic [IdxW-1:0] rd_addr_i,
  output fct_pkg::entry_t      rd_data_o
);

  fct_pkg::entry_t mem_q [TableDepth];
  fct_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire
